// ===== hdl/sdd_pkg.sv =====
// Shared types, constants and the character font of the seven-segment driver.
// Depends on nothing; the front, back, top level and bench import it.
package sdd_pkg;

  // Default number of multiplexed digits
  localparam int NUM_DIGITS_DEF = 3;
  // Depth of the command queue and of the result queue
  localparam int QUEUE_DEPTH = 2;
  // Digit selects that the select field can show
  localparam int SEL_DIGITS = 3;

  localparam logic [7:0] CHAR_DOT         = 8'h2E;
  localparam logic [7:0] CHAR_NONE        = 8'h00;
  localparam logic [7:0] GLYPH_EIGHT      = 8'h7F;
  localparam logic [7:0] GLYPH_UNDERSCORE = 8'h08;
  localparam logic [7:0] GLYPH_BLANK      = 8'h00;
  localparam int         POINT_BIT        = 7;
  localparam logic [2:0] DRIVE_OFF        = 3'b111;

  // Operation codes on the input port
  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_CHAR  = 3'd1,
    OP_POINT = 3'd2,
    OP_TEST  = 3'd3,
    OP_OFF   = 3'd4
  } op_t;

  // Command kinds after classification
  typedef enum logic [2:0] {
    K_TICK,
    K_DOT,
    K_GLYPH,
    K_NONE,
    K_POINT,
    K_TEST,
    K_OFF,
    K_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] glyph;
    logic       last;
    logic [1:0] pos;
    logic       flag;
  } cmd_t;

  typedef struct packed {
    logic [7:0] segments;
    logic [2:0] digit_enable_n;
    logic       test_active;
  } res_t;

  // Map a character to segments A..G; unknown codes show an underscore
  function automatic logic [7:0] font_lookup(input logic [7:0] c);
    logic [7:0] g;
    unique case (c)
      8'h2D:   g = 8'h40; // '-'
      8'h20:   g = 8'h00; // ' '
      8'h30:   g = 8'h3F;
      8'h31:   g = 8'h06;
      8'h32:   g = 8'h5B;
      8'h33:   g = 8'h4F;
      8'h34:   g = 8'h66;
      8'h35:   g = 8'h6D;
      8'h36:   g = 8'h7D;
      8'h37:   g = 8'h07;
      8'h38:   g = 8'h7F;
      8'h39:   g = 8'h6F;
      8'h41:   g = 8'h77; // 'A'
      8'h42:   g = 8'h7C;
      8'h43:   g = 8'h39;
      8'h44:   g = 8'h5E;
      8'h45:   g = 8'h79;
      8'h46:   g = 8'h71;
      8'h48:   g = 8'h76;
      8'h4C:   g = 8'h38;
      8'h4E:   g = 8'h37;
      8'h4F:   g = 8'h3F;
      8'h50:   g = 8'h73;
      8'h52:   g = 8'h31;
      default: g = GLYPH_UNDERSCORE;
    endcase
    return g;
  endfunction

endpackage

// ===== hdl/sdd_fifo.sv =====
// Small register queue used between front and back and on the result side.
// Depends on nothing outside this file.
module sdd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_wr, do_rd;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign do_wr = wr_en & ~full;
  assign do_rd = rd_en & ~empty;
  assign rd_data = mem_r[rd_ptr_r];

  // Advance pointers and occupancy on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== hdl/sdd_front.sv =====
// Front end: decodes an input item into a command and looks up its glyph.
// Depends on sdd_pkg.
module sdd_front import sdd_pkg::*; (
  input  logic [2:0] op,
  input  logic [7:0] char_code,
  input  logic       last_char,
  input  logic [1:0] digit_pos,
  input  logic       flag,
  output cmd_t       cmd
);

  // Classify the operation and the character
  always_comb begin
    cmd.glyph = font_lookup(char_code);
    cmd.last  = last_char;
    cmd.pos   = digit_pos;
    cmd.flag  = flag;
    unique case (op)
      OP_TICK:  cmd.kind = K_TICK;
      OP_CHAR: begin
        if (char_code == CHAR_DOT) begin
          cmd.kind = K_DOT;
        end else if (char_code == CHAR_NONE) begin
          cmd.kind = K_NONE;
        end else begin
          cmd.kind = K_GLYPH;
        end
      end
      OP_POINT: cmd.kind = K_POINT;
      OP_TEST:  cmd.kind = K_TEST;
      OP_OFF:   cmd.kind = K_OFF;
      default:  cmd.kind = K_NOP;
    endcase
  end

endmodule

// ===== hdl/sdd_back.sv =====
// Back end: executes commands on the display state and forms each result.
// Depends on sdd_pkg.
module sdd_back import sdd_pkg::*; #(
  parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  cmd_t cmd,
  input  logic cmd_valid,
  output logic cmd_take,
  input  logic res_ready,
  output res_t res,
  output logic res_valid
);

  localparam int IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int CNT_W = $clog2(NUM_DIGITS + 1);

  logic [7:0]       gbuf_r  [NUM_DIGITS];
  logic [7:0]       gbuf_nxt[NUM_DIGITS];
  // Staged glyphs, newest at index 0 (already right-justified)
  logic [7:0]       stage_r  [NUM_DIGITS];
  logic [7:0]       stage_nxt[NUM_DIGITS];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic             prev_dot_r, prev_dot_nxt;
  logic             test_r, test_nxt;
  logic             off_r, off_nxt;
  logic [IDX_W-1:0] scan_r, scan_nxt;
  logic [7:0]       seg_r, seg_nxt;
  logic [2:0]       drive_r, drive_nxt;
  logic             push_en;
  logic [7:0]       push_g;

  assign cmd_take  = cmd_valid & res_ready;
  assign res_valid = cmd_take;
  assign res       = '{segments: seg_nxt, digit_enable_n: drive_nxt, test_active: test_nxt};

  // Work out the state after the current command
  always_comb begin
    gbuf_nxt     = gbuf_r;
    stage_nxt    = stage_r;
    cnt_nxt      = cnt_r;
    ovf_nxt      = ovf_r;
    prev_dot_nxt = prev_dot_r;
    test_nxt     = test_r;
    off_nxt      = off_r;
    scan_nxt     = scan_r;
    seg_nxt      = seg_r;
    drive_nxt    = drive_r;
    push_en      = 1'b0;
    push_g       = GLYPH_UNDERSCORE;
    unique case (cmd.kind)
      K_TICK: begin
        drive_nxt = DRIVE_OFF;
        if (!off_r) begin
          seg_nxt = gbuf_r[scan_r];
          if (32'(scan_r) < SEL_DIGITS) begin
            drive_nxt = ~(3'b001 << scan_r);
          end
          scan_nxt = (scan_r == IDX_W'(NUM_DIGITS - 1)) ? '0 : scan_r + 1'b1;
        end
      end
      K_DOT, K_GLYPH, K_NONE: begin
        if (cmd.kind == K_DOT) begin
          if (!prev_dot_r) begin
            // Light the point of the glyph just staged
            if (!ovf_r && cnt_r != '0) begin
              stage_nxt[0][POINT_BIT] = 1'b1;
            end
          end else begin
            push_en = 1'b1;
          end
          prev_dot_nxt = 1'b1;
        end else if (cmd.kind == K_GLYPH) begin
          push_en      = 1'b1;
          push_g       = cmd.glyph;
          prev_dot_nxt = 1'b0;
        end
        // Stage a glyph, or drop it once the digits are used up
        if (push_en) begin
          if (!ovf_r && cnt_r < CNT_W'(NUM_DIGITS)) begin
            stage_nxt[0] = push_g;
            for (int i = 1; i < NUM_DIGITS; i++) begin
              stage_nxt[i] = stage_r[i-1];
            end
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        // Commit the layout unless test mode holds the display, and restart staging
        if (cmd.last) begin
          if (!test_r) begin
            for (int p = 0; p < NUM_DIGITS; p++) begin
              gbuf_nxt[p] = (CNT_W'(p) < cnt_nxt) ? stage_nxt[p] : GLYPH_BLANK;
            end
          end
          cnt_nxt      = '0;
          ovf_nxt      = 1'b0;
          prev_dot_nxt = 1'b1;
        end
      end
      K_POINT: begin
        if (32'(cmd.pos) < NUM_DIGITS) begin
          gbuf_nxt[IDX_W'(cmd.pos)][POINT_BIT] = cmd.flag;
        end
      end
      K_TEST: begin
        // Entering test mode shows 888
        if (!test_r && cmd.flag) begin
          for (int p = 0; p < NUM_DIGITS; p++) begin
            gbuf_nxt[p] = (p < SEL_DIGITS) ? GLYPH_EIGHT : GLYPH_BLANK;
          end
        end
        test_nxt = cmd.flag;
      end
      K_OFF:   off_nxt = cmd.flag;
      default: ;
    endcase
  end

  // Update state on each executed command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_DIGITS; p++) begin
        gbuf_r[p]  <= GLYPH_EIGHT;
        stage_r[p] <= GLYPH_BLANK;
      end
      cnt_r      <= '0;
      ovf_r      <= 1'b0;
      prev_dot_r <= 1'b1;
      test_r     <= 1'b1;
      off_r      <= 1'b0;
      scan_r     <= '0;
      seg_r      <= '0;
      drive_r    <= DRIVE_OFF;
    end else if (cmd_take) begin
      gbuf_r     <= gbuf_nxt;
      stage_r    <= stage_nxt;
      cnt_r      <= cnt_nxt;
      ovf_r      <= ovf_nxt;
      prev_dot_r <= prev_dot_nxt;
      test_r     <= test_nxt;
      off_r      <= off_nxt;
      scan_r     <= scan_nxt;
      seg_r      <= seg_nxt;
      drive_r    <= drive_nxt;
    end
  end

endmodule

// ===== hdl/seven_segment_mux_driver.sv =====
// Top level of the multiplexed seven-segment driver: front, command queue,
// back end and result queue. Depends on sdd_pkg, sdd_front, sdd_fifo, sdd_back.
//
//   channel   handshake        payload
//   input     push / full      in_op, in_char_code, in_last_char, in_digit_pos, in_flag
//   result    empty / pop      out_segments, out_digit_enable_n, out_test_active
//
// One item per cycle sustained while results are popped; every item gives exactly one result.
// A pushed item is written into the command queue, executed by the back end
// and written into the result queue, whose head drives the result ports until
// it is popped; a full result queue holds it back in the command queue.
// Both queues hold two entries; a stalled pop fills the result queue, then
// the command queue, and only then raises full.
// Synchronous reset empties both queues and loads 888 with test mode on.
module seven_segment_mux_driver import sdd_pkg::*; #(
  parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [2:0] in_op,
  input  logic [7:0] in_char_code,
  input  logic       in_last_char,
  input  logic [1:0] in_digit_pos,
  input  logic       in_flag,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_segments,
  output logic [2:0] out_digit_enable_n,
  output logic       out_test_active
);

  cmd_t cmd_in, cmd_q;
  logic cmd_empty, cmd_take;
  res_t res_in, res_q;
  logic res_valid, res_full;

  // Classify incoming items
  sdd_front u_front (
    .op        (in_op),
    .char_code (in_char_code),
    .last_char (in_last_char),
    .digit_pos (in_digit_pos),
    .flag      (in_flag),
    .cmd       (cmd_in)
  );

  // Hold commands between front and back
  sdd_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(QUEUE_DEPTH)) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (cmd_in),
    .full    (full),
    .rd_en   (cmd_take),
    .rd_data (cmd_q),
    .empty   (cmd_empty)
  );

  // Execute commands
  sdd_back #(.NUM_DIGITS(NUM_DIGITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_q),
    .cmd_valid (~cmd_empty),
    .cmd_take  (cmd_take),
    .res_ready (~res_full),
    .res       (res_in),
    .res_valid (res_valid)
  );

  // Hold results until transferred
  sdd_fifo #(.WIDTH($bits(res_t)), .DEPTH(QUEUE_DEPTH)) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_valid),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_q),
    .empty   (empty)
  );

  assign out_segments       = res_q.segments;
  assign out_digit_enable_n = res_q.digit_enable_n;
  assign out_test_active    = res_q.test_active;

endmodule

// ===== hdl/sdd_checker.sv =====
// Port-level checks of the seven-segment driver, bound to the top level.
// Depends on the top level's port names only.
module sdd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_segments,
  input logic [2:0] out_digit_enable_n
);

  // Reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  // A transfer while no result is waiting yields a result through both queues
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full && empty) |-> ##2 !empty)
    else $error("result missing two cycles after transfer");

  // At most one digit is driven at a time
  a_one_digit: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> $countones(~out_digit_enable_n) <= 1)
    else $error("more than one digit selected");

  // A waiting result holds while not transferred
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_segments)))
    else $error("waiting result changed");

endmodule

bind seven_segment_mux_driver sdd_checker u_sdd_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for seven_segment_mux_driver: a directed opening, then about
// a thousand random commands, each result checked against an in-bench display model.
// Depends on sdd_pkg and the seven_segment_mux_driver RTL.
module tb;
  import sdd_pkg::*;

  localparam int DIGITS         = NUM_DIGITS_DEF;
  localparam int TOTAL_ITEMS    = 1000;
  localparam int HOLD_CYCLES    = 90;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_REPORTS    = 10;
  localparam logic [2:0] OP_RESERVED_LO = 3'd5;
  localparam logic [2:0] OP_RESERVED_HI = 3'd7;

  typedef struct {
    logic [2:0]  op;
    logic [7:0]  code;
    logic        last;
    logic [1:0]  pos;
    logic        flag;
    int unsigned gap;
    bit          drain;
  } cmd_item_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic       pop = 1'b0;
  logic       full;
  logic       empty;
  logic [2:0] in_op = '0;
  logic [7:0] in_char_code = '0;
  logic       in_last_char = 1'b0;
  logic [1:0] in_digit_pos = '0;
  logic       in_flag = 1'b0;
  logic [7:0] out_segments;
  logic [2:0] out_digit_enable_n;
  logic       out_test_active;

  cmd_item_t command_q[$];
  res_t      pending_frames[$];

  // Display model state
  logic [7:0] shown [DIGITS];
  logic [7:0] staged [DIGITS];
  int         staged_cnt;
  bit         staged_drop;
  bit         after_dot;
  bit         test_on;
  bit         blank_on;
  int         scan_idx;
  logic [7:0] seg_drive;
  logic [2:0] sel_drive_n;

  int n_live, n_sent, n_got, n_fails, n_total;
  int n_chars, n_ticks, n_test_entries, n_holds, n_drains;
  bit tx_eager, rx_eager;

  // Driver and monitor bookkeeping
  cmd_item_t cur;
  int        gap_left;
  bit        head_armed;
  logic      next_push;
  res_t      predicted;
  int        wait_left;
  int        got_now;
  res_t      want;

  seven_segment_mux_driver u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_op              (in_op),
    .in_char_code       (in_char_code),
    .in_last_char       (in_last_char),
    .in_digit_pos       (in_digit_pos),
    .in_flag            (in_flag),
    .empty              (empty),
    .pop                (pop),
    .out_segments       (out_segments),
    .out_digit_enable_n (out_digit_enable_n),
    .out_test_active    (out_test_active)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Segment pattern of one character; anything outside the font shows an underscore
  function automatic logic [7:0] char_segments(input logic [7:0] c);
    case (c)
      "-": return 8'h40;
      " ": return 8'h00;
      "0": return 8'h3F;
      "1": return 8'h06;
      "2": return 8'h5B;
      "3": return 8'h4F;
      "4": return 8'h66;
      "5": return 8'h6D;
      "6": return 8'h7D;
      "7": return 8'h07;
      "8": return 8'h7F;
      "9": return 8'h6F;
      "A": return 8'h77;
      "B": return 8'h7C;
      "C": return 8'h39;
      "D": return 8'h5E;
      "E": return 8'h79;
      "F": return 8'h71;
      "H": return 8'h76;
      "L": return 8'h38;
      "N": return 8'h37;
      "O": return 8'h3F;
      "P": return 8'h73;
      "R": return 8'h31;
      default: return GLYPH_UNDERSCORE;
    endcase
  endfunction

  task automatic display_reset();
    for (int p = 0; p < DIGITS; p++) begin
      shown[p]  = GLYPH_EIGHT;
      staged[p] = GLYPH_BLANK;
    end
    staged_cnt  = 0;
    staged_drop = 1'b0;
    after_dot   = 1'b1;
    test_on     = 1'b1;
    blank_on    = 1'b0;
    scan_idx    = 0;
    seg_drive   = GLYPH_BLANK;
    sel_drive_n = DRIVE_OFF;
  endtask

  // Stage a glyph, or mark the string as overflowed once all digits are taken
  task automatic stage_glyph(input logic [7:0] g);
    if (!staged_drop && staged_cnt < DIGITS) begin
      staged[staged_cnt] = g;
      staged_cnt++;
    end else begin
      staged_drop = 1'b1;
    end
  endtask

  // Advance the display model by one command and return the frame it shows after it
  task automatic advance_display(input cmd_item_t it, output res_t frame);
    case (it.op)
      OP_TICK: begin
        n_ticks++;
        sel_drive_n = DRIVE_OFF;
        if (!blank_on) begin
          seg_drive   = shown[scan_idx];
          sel_drive_n = ~(3'b001 << scan_idx);
          scan_idx    = (scan_idx == DIGITS - 1) ? 0 : scan_idx + 1;
        end
      end
      OP_CHAR: begin
        n_chars++;
        if (it.code == CHAR_DOT) begin
          // a dot after a glyph lights its point, otherwise it is a glyph itself
          if (!after_dot) begin
            if (!staged_drop && staged_cnt > 0) staged[staged_cnt - 1][POINT_BIT] = 1'b1;
          end else begin
            stage_glyph(GLYPH_UNDERSCORE);
          end
          after_dot = 1'b1;
        end else if (it.code != CHAR_NONE) begin
          stage_glyph(char_segments(it.code));
          after_dot = 1'b0;
        end
        // commit right-justified unless test mode holds the display
        if (it.last) begin
          if (!test_on) begin
            for (int p = 0; p < DIGITS; p++)
              shown[p] = (p < staged_cnt) ? staged[staged_cnt - 1 - p] : GLYPH_BLANK;
          end
          staged_cnt  = 0;
          staged_drop = 1'b0;
          after_dot   = 1'b1;
        end
      end
      OP_POINT: begin
        if (it.pos < DIGITS) shown[it.pos][POINT_BIT] = it.flag;
      end
      OP_TEST: begin
        if (!test_on && it.flag) begin
          n_test_entries++;
          for (int p = 0; p < DIGITS; p++) shown[p] = (p < 3) ? GLYPH_EIGHT : GLYPH_BLANK;
        end
        test_on = it.flag;
      end
      OP_OFF: blank_on = it.flag;
      default: ;
    endcase
    frame.segments       = seg_drive;
    frame.digit_enable_n = sel_drive_n;
    frame.test_active    = test_on;
  endtask

  // Command with random payload fields and a random gap unless eager; callers override the fields the op uses
  function automatic cmd_item_t rand_cmd(input logic [2:0] op);
    cmd_item_t it;
    it.op    = op;
    it.code  = 8'($urandom_range(0, 255));
    it.last  = 1'($urandom_range(0, 1));
    it.pos   = 2'($urandom_range(0, 3));
    it.flag  = 1'($urandom_range(0, 1));
    it.gap   = tx_eager ? 0 : $urandom_range(0, 11);
    it.drain = 1'b0;
    return it;
  endfunction

  function automatic logic [7:0] pick_char();
    string pool;
    int    sel;
    pool = "0123456789ABCDEFHLNOPR- ";
    sel  = $urandom_range(0, 9);
    if (sel < 5) return pool[$urandom_range(0, pool.len() - 1)];
    if (sel < 7) return CHAR_DOT;
    if (sel < 8) return CHAR_NONE;
    return 8'($urandom_range(0, 255));
  endfunction

  // Queue a command; every 200th live command first waits for the display to drain
  task automatic enqueue(input cmd_item_t it);
    if (it.op <= OP_OFF) begin
      n_live++;
      if (n_live % 200 == 0) it.drain = 1'b1;
    end
    command_q.push_back(it);
  endtask

  task automatic add_char(input logic [7:0] code, input logic last);
    cmd_item_t it;
    it      = rand_cmd(OP_CHAR);
    it.code = code;
    it.last = last;
    enqueue(it);
  endtask

  task automatic add_op(input logic [2:0] op, input logic [1:0] pos, input logic flag);
    cmd_item_t it;
    it      = rand_cmd(op);
    it.pos  = pos;
    it.flag = flag;
    enqueue(it);
  endtask

  task automatic add_tick();
    enqueue(rand_cmd(OP_TICK));
  endtask

  task automatic build_directed();
    cmd_item_t it;
    // test pattern after reset, point set while test mode holds the display
    add_tick();
    add_op(OP_POINT, 2'd1, 1'b1);
    add_op(OP_POINT, 2'd3, 1'b1);
    add_tick();
    add_char("1", 1'b1);
    // leave test mode once the display has drained
    it       = rand_cmd(OP_TEST);
    it.flag  = 1'b0;
    it.drain = 1'b1;
    enqueue(it);
    // leading dot, dot on a glyph, unknown code
    add_char(CHAR_DOT, 1'b0);
    add_char("5", 1'b0);
    add_char(CHAR_DOT, 1'b0);
    add_char(8'hFF, 1'b1);
    add_tick();
    // overflow, then a dot after the dropped glyph
    add_char("A", 1'b0);
    add_char("B", 1'b0);
    add_char("C", 1'b0);
    add_char("D", 1'b0);
    add_char(CHAR_DOT, 1'b1);
    // repeated dot
    add_char("7", 1'b0);
    add_char(CHAR_DOT, 1'b0);
    add_char(CHAR_DOT, 1'b1);
    // empty commit blanks the display
    add_char(CHAR_NONE, 1'b1);
    add_op(OP_OFF, 2'd0, 1'b1);
    add_tick();
    add_op(OP_OFF, 2'd0, 1'b0);
    add_op(OP_RESERVED_LO, 2'd3, 1'b1);
    add_op(OP_TEST, 2'd0, 1'b1);
    add_op(OP_TEST, 2'd0, 1'b1);
    add_tick();
  endtask

  task automatic build_random();
    int choice;
    int len;
    while (n_live < TOTAL_ITEMS) begin
      if ($urandom_range(0, 24) == 0) tx_eager = ~tx_eager;
      choice = $urandom_range(0, 99);
      if (choice < 45) begin
        // text string, now and then without its last mark or with ticks inside
        len = $urandom_range(1, 5);
        for (int k = 0; k < len; k++) begin
          add_char(pick_char(), (k == len - 1) && ($urandom_range(0, 9) != 0));
          if ($urandom_range(0, 3) == 0) add_tick();
        end
      end else if (choice < 75) begin
        repeat ($urandom_range(1, 4)) add_tick();
      end else if (choice < 83) begin
        add_op(OP_POINT, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end else if (choice < 88) begin
        add_op(OP_TEST, 2'($urandom_range(0, 3)), $urandom_range(0, 2) == 0);
      end else if (choice < 93) begin
        add_op(OP_OFF, 2'($urandom_range(0, 3)), $urandom_range(0, 3) == 0);
      end else if (choice < 96) begin
        enqueue(rand_cmd(3'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI))));
      end else begin
        enqueue(rand_cmd(3'($urandom_range(0, 7))));
      end
    end
  endtask

  // Driver: predict on each transfer, then offer the next command after its gap
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      next_push = push;
      if (push && !full) begin
        advance_display(cur, predicted);
        pending_frames.push_back(predicted);
        n_sent++;
        next_push = 1'b0;
      end
      if (!next_push && command_q.size() != 0) begin
        if (!head_armed) begin
          gap_left   = command_q[0].gap;
          head_armed = 1'b1;
        end
        if (gap_left > 0) begin
          gap_left--;
        end else if (!(command_q[0].drain && n_got != n_sent)) begin
          cur        = command_q.pop_front();
          head_armed = 1'b0;
          if (cur.drain) n_drains++;
          in_op        <= cur.op;
          in_char_code <= cur.code;
          in_last_char <= cur.last;
          in_digit_pos <= cur.pos;
          in_flag      <= cur.flag;
          next_push    = 1'b1;
        end
      end
      push <= next_push;
    end
  end

  // Monitor: check each transfer against the oldest frame, then draw the next stall
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        got_now = n_got + 1;
        n_got <= got_now;
        if (pending_frames.size() == 0) begin
          n_fails++;
          if (n_fails <= MAX_REPORTS)
            $display("result %0d with nothing pending: segments %02h enables %03b test %0b",
                     got_now, out_segments, out_digit_enable_n, out_test_active);
        end else begin
          want = pending_frames.pop_front();
          if (want.segments !== out_segments || want.digit_enable_n !== out_digit_enable_n ||
              want.test_active !== out_test_active) begin
            n_fails++;
            if (n_fails <= MAX_REPORTS)
              $display({"result %0d mismatch: segments exp %02h got %02h, ",
                        "enables exp %03b got %03b, test exp %0b got %0b"},
                       got_now, want.segments, out_segments, want.digit_enable_n,
                       out_digit_enable_n, want.test_active, out_test_active);
          end
        end
        if (got_now % 64 == 0) rx_eager = 1'($urandom_range(0, 1));
        wait_left = rx_eager ? 0 : $urandom_range(0, 11);
        // long hold-off away from the drain points so the queues fill and full rises
        if (got_now == 300 || got_now == 700) begin
          wait_left = HOLD_CYCLES;
          n_holds++;
        end
      end
      if (wait_left > 0) begin
        wait_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    @(posedge rst_n);
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin
    display_reset();
    build_directed();
    build_random();
    n_total = command_q.size();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // hold until every queued command has come back as a frame
    while (n_got != n_total) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_frames.size() != 0) begin
      n_fails++;
      $display("%0d expected frames never arrived", pending_frames.size());
    end
    $display("checked %0d frames from %0d commands: %0d characters, %0d ticks, %0d test entries",
             n_got, n_sent, n_chars, n_ticks, n_test_entries);
    $display("receiver hold-offs: %0d, sender drain pauses: %0d, failures: %0d",
             n_holds, n_drains, n_fails);
    if (n_fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
